### rtl/core/bhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhm_pkg;

  // Fixed field widths
  localparam int KEY_W    = 31;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 10;

  // Defaults for the top-level parameters
  localparam int BUCKET_COUNT_DEF     = 10;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  // Modulo unit: reciprocal of the bucket count and the key * reciprocal product
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int REM_W   = BUCKET_W + 1;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes; the unused code behaves as a find
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_FIND   = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  // Status codes
  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_ABSENT = 2'd1;
  localparam status_t STATUS_FULL   = 2'd2;

  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [BUCKET_W-1:0] bucket;
  } out_item_t;

  // One memory word: valid flag plus stored key
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/bhm_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// key % BUCKET_COUNT by reciprocal multiplication; done follows start through registers s1_r, s2_r and done_r.
module bhm_mod_unit #(
  parameter int BUCKET_COUNT = bhm_pkg::BUCKET_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bhm_pkg::KEY_W-1:0]    key,
  output logic                              done,
  output logic [bhm_pkg::BUCKET_W-1:0]      rem
);

  // (key * RECIP) >> SHIFT is the exact quotient for every key below 2**KEY_W
  localparam int SHIFT = bhm_pkg::KEY_W + $clog2(BUCKET_COUNT);
  localparam logic [63:0] RECIP_L =
    ((64'd1 << SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
  localparam logic [bhm_pkg::RECIP_W-1:0] RECIP = bhm_pkg::RECIP_W'(RECIP_L);
  localparam logic [bhm_pkg::KEY_W-1:0]   DIV_C = bhm_pkg::KEY_W'(BUCKET_COUNT);

  logic                             s1_r;
  logic                             s2_r;
  logic                             done_r;
  logic [bhm_pkg::KEY_W-1:0]        key_r;
  logic [bhm_pkg::PROD_W-1:0]       prod_r;
  logic [bhm_pkg::BUCKET_W-1:0]     rem_r;
  logic [bhm_pkg::KEY_W-1:0]        quo;
  logic [bhm_pkg::KEY_W-1:0]        rem_full;

  // quo * DIV_C never exceeds the key, so the 31-bit product is exact
  assign quo      = bhm_pkg::KEY_W'(prod_r >> SHIFT);
  assign rem_full = key_r - (quo * DIV_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    if (s1_r) begin
      prod_r <= bhm_pkg::PROD_W'(key_r) * bhm_pkg::PROD_W'(RECIP);
    end
    if (s2_r) begin
      rem_r <= bhm_pkg::BUCKET_W'(rem_full);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/core/bucketed_hash_multiset_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Bucketed hash multiset. Each transaction carries a command (insert, find,
// delete one copy) and a 31-bit key; the bucket is key % BUCKET_COUNT and
// holds SLOTS_PER_BUCKET slots in one single-port-style synchronous RAM of
// BUCKET_COUNT*SLOTS_PER_BUCKET words. A transaction is taken when start is
// high and busy is low; exactly one result follows, shown for one cycle with
// out_valid. The receiver cannot stall: sample out_data whenever out_valid
// is high. From accept, a transaction passes through the hash state, where
// the modulo unit does a reciprocal multiply, then a multiply-back and
// subtract; then through the slot scan, one RAM read per cycle with
// registered read data, which stops at the first matching slot or at the
// last slot; then through the done state, which writes the slot back for
// an insert or delete that hit. busy drops in the cycle out_valid rises,
// so the next transaction can be taken then. After reset the block clears
// the valid flags of all BUCKET_COUNT*SLOTS_PER_BUCKET words, with busy
// held high. Duplicates are kept; insert into a full bucket reports FULL.
module bucketed_hash_multiset_core #(
  parameter int BUCKET_COUNT     = bhm_pkg::BUCKET_COUNT_DEF,
  parameter int SLOTS_PER_BUCKET = bhm_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bhm_pkg::in_item_t in_data,
  output logic                   out_valid,
  output bhm_pkg::out_item_t     out_data
);

  localparam int TOTAL = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SCW   = $clog2(SLOTS_PER_BUCKET + 1);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  bhm_pkg::state_t                 state_r, state_nxt;
  bhm_pkg::cmd_t                   cmd_r;
  logic [bhm_pkg::KEY_W-1:0]       key_r;
  logic [bhm_pkg::BUCKET_W-1:0]    bkt_r;
  logic [AW-1:0]                   base_r;
  logic [AW-1:0]                   clr_cnt_r;
  logic [SCW-1:0]                  issue_cnt_r;   // next slot to read
  logic                            rd_vld_r;      // rd_data_r holds slot rd_slot_r
  logic [SW-1:0]                   rd_slot_r;
  logic                            hit_r;
  logic [SW-1:0]                   hit_slot_r;
  logic                            out_valid_r, out_valid_nxt;
  bhm_pkg::out_item_t              out_data_r, out_data_nxt;
  bhm_pkg::slot_t                  rd_data_r;

  // RAM port controls
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  bhm_pkg::slot_t                  wr_data;

  // modulo unit
  logic                            mod_start;
  logic                            mod_done;
  logic [bhm_pkg::BUCKET_W-1:0]    mod_rem;

  logic                            accept;
  logic                            is_insert;
  logic                            slot_match;
  logic                            last_slot;
  logic                            clr_last;

  assign accept    = start && !busy;
  assign is_insert = (cmd_r == bhm_pkg::CMD_INSERT);
  assign last_slot = (rd_slot_r == SW'(SLOTS_PER_BUCKET - 1));
  assign clr_last  = (clr_cnt_r == AW'(TOTAL - 1));

  // Insert stops at the first free slot; find/delete at the first live match.
  assign slot_match = is_insert ? !rd_data_r.valid
                                : (rd_data_r.valid && (rd_data_r.key == key_r));

  bhm_mod_unit #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .key  (in_data.key),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // ---------------------------------------------------------------------
  // Slot RAM: one word per slot, read data registered. Writes happen only in
  // the clear sweep and the final cycle of a transaction, after all reads of
  // that transaction, so no same-entry overlap can occur.
  // ---------------------------------------------------------------------
  bhm_pkg::slot_t slot_mem [TOTAL];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bhm_pkg::ST_CLEAR: if (clr_last) state_nxt = bhm_pkg::ST_IDLE;
      bhm_pkg::ST_IDLE:  if (start)    state_nxt = bhm_pkg::ST_HASH;
      bhm_pkg::ST_HASH:  if (mod_done) state_nxt = bhm_pkg::ST_SCAN;
      bhm_pkg::ST_SCAN: begin
        if (rd_vld_r && (slot_match || last_slot)) begin
          state_nxt = bhm_pkg::ST_DONE;
        end
      end
      bhm_pkg::ST_DONE:  state_nxt = bhm_pkg::ST_IDLE;
      default:           state_nxt = bhm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs of the sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    busy          = 1'b1;
    mod_start     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = base_r + AW'(issue_cnt_r);
    wr_en         = 1'b0;
    wr_addr       = base_r + AW'(hit_slot_r);
    wr_data.valid = is_insert;
    wr_data.key   = key_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      bhm_pkg::ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_cnt_r;
        wr_data.valid = 1'b0;
        wr_data.key   = '0;
      end
      bhm_pkg::ST_IDLE: begin
        busy      = 1'b0;
        mod_start = start;
      end
      bhm_pkg::ST_HASH: ;
      bhm_pkg::ST_SCAN: begin
        rd_en = (issue_cnt_r < SCW'(SLOTS_PER_BUCKET));
      end
      bhm_pkg::ST_DONE: begin
        // insert claims the free slot, delete drops the matched copy
        wr_en         = hit_r && (is_insert || (cmd_r == bhm_pkg::CMD_DELETE));
        out_valid_nxt = 1'b1;
        out_data_nxt.bucket = bkt_r;
        if (hit_r) begin
          out_data_nxt.status = bhm_pkg::STATUS_OK;
        end else if (is_insert) begin
          out_data_nxt.status = bhm_pkg::STATUS_FULL;
        end else begin
          out_data_nxt.status = bhm_pkg::STATUS_ABSENT;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhm_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == bhm_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == bhm_pkg::ST_HASH) begin
        issue_cnt_r <= '0;
        rd_vld_r    <= 1'b0;
        hit_r       <= 1'b0;
      end else if (state_r == bhm_pkg::ST_SCAN) begin
        rd_vld_r <= rd_en;
        if (rd_en) begin
          issue_cnt_r <= issue_cnt_r + 1'b1;
        end
        if (rd_vld_r && slot_match) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key;
    end
    if ((state_r == bhm_pkg::ST_HASH) && mod_done) begin
      bkt_r  <= mod_rem;
      base_r <= AW'(mod_rem * SLOTS_PER_BUCKET);
    end
    if (rd_en) begin
      rd_slot_r <= issue_cnt_r[SW-1:0];
    end
    if ((state_r == bhm_pkg::ST_SCAN) && rd_vld_r && slot_match) begin
      hit_slot_r <= rd_slot_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == bhm_pkg::ST_CLEAR || state_r == bhm_pkg::ST_DONE))
    else $error("slot RAM written outside clear sweep or completion");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_data_r.bucket} < bhm_pkg::REM_W'(BUCKET_COUNT)))
    else $error("bucket index out of range");

  a_no_read_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("slot RAM read and write in the same cycle");

endmodule

`default_nettype wire

### tb/bucketed_hash_multiset_checker.sv
`timescale 1ns / 1ps

module bucketed_hash_multiset_checker #(
  parameter int BUCKET_COUNT     = bhm_pkg::BUCKET_COUNT_DEF,
  parameter int SLOTS_PER_BUCKET = bhm_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  bhm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  bhm_pkg::out_item_t out_data,
  output int                 err_count,
  output int                 pending
);

  localparam int TOTAL_SLOTS = BUCKET_COUNT * SLOTS_PER_BUCKET;

  logic [bhm_pkg::KEY_W-1:0] table_key   [TOTAL_SLOTS];
  logic                      table_valid [TOTAL_SLOTS];
  bhm_pkg::out_item_t        expected_results [$];

  // Updates the shadow table for one command and returns its result.
  function automatic bhm_pkg::out_item_t apply_command(bhm_pkg::in_item_t item);
    int                 bkt;
    int                 base;
    int                 hit;
    bhm_pkg::out_item_t res;
    bkt  = int'({1'b0, item.key} % BUCKET_COUNT);
    base = bkt * SLOTS_PER_BUCKET;
    hit  = -1;
    res.bucket = bhm_pkg::BUCKET_W'(bkt);
    if (item.command == bhm_pkg::CMD_INSERT) begin
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
        if (hit < 0 && !table_valid[base + s]) hit = s;
      end
      if (hit >= 0) begin
        table_key[base + hit]   = item.key;
        table_valid[base + hit] = 1'b1;
        res.status = bhm_pkg::STATUS_OK;
      end else begin
        res.status = bhm_pkg::STATUS_FULL;
      end
    end else begin
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
        if (hit < 0 && table_valid[base + s] && table_key[base + s] == item.key) hit = s;
      end
      res.status = (hit >= 0) ? bhm_pkg::STATUS_OK : bhm_pkg::STATUS_ABSENT;
      // delete drops the lowest matching copy only
      if (item.command == bhm_pkg::CMD_DELETE && hit >= 0) table_valid[base + hit] = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    bhm_pkg::out_item_t want;
    if (!rst_n) begin
      foreach (table_valid[i]) table_valid[i] = 1'b0;
      expected_results.delete();
      err_count = 0;
    end else begin
      // retire the result first; a new command can be taken on the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result status=%0d bucket=%0d", $time,
                   out_data.status, out_data.bucket);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data.status);
          end
          if (out_data.bucket !== want.bucket) begin
            err_count++;
            $display("%0t: bucket expected %0d actual %0d", $time, want.bucket,
                     out_data.bucket);
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_command(in_data));
    end
    pending = expected_results.size();
  end

endmodule

### tb/bucketed_hash_multiset_test.sv
`timescale 1ns / 1ps

module bucketed_hash_multiset_core_test;

  // The spare command code; the block treats it as a find.
  localparam bhm_pkg::cmd_t CMD_UNUSED = 2'd3;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int PHASE_ITEMS  = 333;      // three idle profiles, ~1000 random items
  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [bhm_pkg::KEY_W-1:0] KEY_MAX = {bhm_pkg::KEY_W{1'b1}};

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  bhm_pkg::in_item_t  in_data;
  logic               out_valid;
  bhm_pkg::out_item_t out_data;
  int                 err_count;
  int                 pending;

  int idle_pct;     // chance per cycle that the sender holds start low
  int insert_pct;   // share of inserts in the random mix
  int cycle_count = 0;

  // Small key pool so finds and deletes actually hit and buckets fill up.
  logic [bhm_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  bucketed_hash_multiset_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  bucketed_hash_multiset_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs (covers the clear sweep after reset).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drives one transaction from a falling edge and returns at the falling edge
  // after it was taken. Idle cycles put junk on in_data with start low.
  // busy is settled at the falling edge and holds through the next rising edge.
  task automatic send_command(input bhm_pkg::cmd_t cmd,
                              input logic [bhm_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= '{command: bhm_pkg::cmd_t'($urandom), key: bhm_pkg::KEY_W'($urandom)};
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= '{command: cmd, key: key};
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned               r;
    bhm_pkg::cmd_t             cmd;
    logic [bhm_pkg::KEY_W-1:0] key;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    idle_pct   = 11;
    insert_pct = 50;
    foreach (key_pool[i]) key_pool[i] = bhm_pkg::KEY_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: key extremes, hit and miss for every command, spare code,
    // full bucket, duplicates, and a slot freed by delete being reused.
    send_command(bhm_pkg::CMD_INSERT, '0);
    send_command(bhm_pkg::CMD_FIND,   '0);
    send_command(bhm_pkg::CMD_INSERT, KEY_MAX);
    send_command(bhm_pkg::CMD_FIND,   KEY_MAX);
    send_command(CMD_UNUSED,          KEY_MAX);
    send_command(CMD_UNUSED,          31'd17);
    send_command(bhm_pkg::CMD_FIND,   31'd17);
    send_command(bhm_pkg::CMD_DELETE, 31'd17);
    // bucket 3: seven distinct keys plus a duplicate fills all eight slots
    send_command(bhm_pkg::CMD_INSERT, 31'd3);
    send_command(bhm_pkg::CMD_INSERT, 31'd13);
    send_command(bhm_pkg::CMD_INSERT, 31'd23);
    send_command(bhm_pkg::CMD_INSERT, 31'd33);
    send_command(bhm_pkg::CMD_INSERT, 31'd43);
    send_command(bhm_pkg::CMD_INSERT, 31'd53);
    send_command(bhm_pkg::CMD_INSERT, 31'd63);
    send_command(bhm_pkg::CMD_INSERT, 31'd3);
    send_command(bhm_pkg::CMD_INSERT, 31'd73);   // full
    send_command(bhm_pkg::CMD_DELETE, 31'd3);    // removes one copy only
    send_command(bhm_pkg::CMD_FIND,   31'd3);
    send_command(bhm_pkg::CMD_INSERT, 31'd73);   // lands in the freed slot
    send_command(bhm_pkg::CMD_DELETE, 31'd3);
    send_command(bhm_pkg::CMD_DELETE, 31'd3);    // both copies gone
    send_command(bhm_pkg::CMD_DELETE, KEY_MAX);
    send_command(bhm_pkg::CMD_FIND,   KEY_MAX);

    // Random: three sender profiles (light, heavy, no idling); insert share
    // shifts so buckets both fill up and drain.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct   = 11;
          insert_pct = 50;
        end
        1: begin
          idle_pct   = 85;
          insert_pct = 20;
        end
        default: begin
          idle_pct   = 0;
          insert_pct = 40;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < insert_pct) cmd = bhm_pkg::CMD_INSERT;
        else if (r < insert_pct + (100 - insert_pct) * 4 / 9) cmd = bhm_pkg::CMD_FIND;
        else if (r < 90) cmd = bhm_pkg::CMD_DELETE;
        else cmd = CMD_UNUSED;
        if ($urandom_range(9) < 7) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else key = bhm_pkg::KEY_W'($urandom);
        send_command(cmd, key);
      end
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
